/* rtl/core/pesc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesc_pkg
// Shared types and constants of the pre-emphasis sample converter.
// ----------------------------------------------------------------------------
package pesc_pkg;

  localparam int MAX_CHANNELS = 8;

  localparam int SAMPLE_W  = 32;
  localparam int CHANNEL_W = 3;
  localparam int RESULT_W  = 16;
  localparam int COEF_W    = 16;
  localparam int FORMAT_W  = 2;

  // Sample format codes
  localparam logic [FORMAT_W-1:0] FMT_S16 = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_S24 = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_S32 = 2'd2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes, one 32-bit word apart
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_FORMAT  = 2'd0;
  localparam reg_idx_t REG_ENABLE  = 2'd1;
  localparam reg_idx_t REG_COEF    = 2'd2;
  localparam reg_idx_t REG_CHANNEL = 2'd3;

  typedef struct packed {
    logic [FORMAT_W-1:0]      sample_format;
    logic                     emphasis_enable;
    logic signed [COEF_W-1:0] emphasis_coef;
    logic [CHANNEL_W-1:0]     selected_channel;
  } cfg_t;

endpackage

/* rtl/core/pesc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesc_regs
// APB register file holding format, emphasis enable, coefficient and channel.
// ----------------------------------------------------------------------------
module pesc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pesc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pesc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pesc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output pesc_pkg::cfg_t                cfg
);

  logic                wr_en;
  pesc_pkg::reg_idx_t  reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index)
        pesc_pkg::REG_FORMAT:  cfg.sample_format    <= pwdata[pesc_pkg::FORMAT_W-1:0];
        pesc_pkg::REG_ENABLE:  cfg.emphasis_enable  <= pwdata[0];
        pesc_pkg::REG_COEF:    cfg.emphasis_coef    <= pwdata[pesc_pkg::COEF_W-1:0];
        pesc_pkg::REG_CHANNEL: cfg.selected_channel <= pwdata[pesc_pkg::CHANNEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      pesc_pkg::REG_FORMAT:  prdata = pesc_pkg::PDATA_W'(cfg.sample_format);
      pesc_pkg::REG_ENABLE:  prdata = pesc_pkg::PDATA_W'(cfg.emphasis_enable);
      pesc_pkg::REG_COEF:    prdata = pesc_pkg::PDATA_W'(unsigned'(cfg.emphasis_coef));
      pesc_pkg::REG_CHANNEL: prdata = pesc_pkg::PDATA_W'(cfg.selected_channel);
      default:               prdata = '0;
    endcase
  end

endmodule

/* rtl/core/pesc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesc_datapath
// Format conversion, multiply-add with the delayed sample, Q15 rounding and
// saturation for one sample.
// ----------------------------------------------------------------------------
module pesc_datapath (
  input  pesc_pkg::cfg_t                         cfg,
  input  logic [pesc_pkg::SAMPLE_W-1:0]          sample,
  input  logic signed [pesc_pkg::RESULT_W-1:0]   prev,
  output logic signed [pesc_pkg::RESULT_W-1:0]   result,
  output logic signed [pesc_pkg::RESULT_W-1:0]   prev_next
);

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  logic signed [15:0] x16;
  logic signed [31:0] s32;
  logic signed [31:0] prod;
  logic signed [33:0] addend;
  logic signed [33:0] acc;
  logic signed [20:0] acc_rnd;
  logic signed [17:0] s_rnd;
  logic signed [15:0] acc_sat;
  logic signed [15:0] s_sat;
  logic               is_s16;

  assign is_s16 = (cfg.sample_format == pesc_pkg::FMT_S16);
  assign x16    = sample[15:0];
  assign s32    = (cfg.sample_format == pesc_pkg::FMT_S24) ? {sample[23:0], 8'h00} : sample;
  assign prod   = prev * cfg.emphasis_coef;

  // 16-bit samples enter the Q30 sum at full scale, wider ones are halved
  assign addend = is_s16 ? {{3{x16[15]}}, x16, 15'd0} : {{3{s32[31]}}, s32[31:1]};
  assign acc    = {{2{prod[31]}}, prod} + addend;

  // add half an LSB, then drop it
  assign acc_rnd = {acc[33], acc[33:14]} + 21'sd1;
  assign s_rnd   = {s32[31], s32[31:15]} + 18'sd1;

  assign acc_sat = sat16(acc_rnd[20:1]);
  assign s_sat   = sat16({{3{s_rnd[17]}}, s_rnd[17:1]});

  always_comb begin
    if (cfg.emphasis_enable) begin
      result = acc_sat;
    end else if (is_s16) begin
      result = x16;
    end else begin
      result = s_sat;
    end
    prev_next = is_s16 ? x16 : s_sat;
  end

endmodule

/* rtl/core/pre_emphasis_sample_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_emphasis_sample_converter
// First-order Q1.15 pre-emphasis filter on one channel of an interleaved
// sample stream, with 16/24/32-bit input format conversion.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on sample_valid/sample_stall with sample_value and
//   channel_index; results leave on result_valid/result_stall with
//   filtered_sample. A transfer happens when valid is high and stall is low.
//   Only samples of selected_channel give a result; others are dropped.
//   From input transfer to result_valid a sample passes one input
//   register, then the format/multiply-add/round stage into the result
//   register. While sample_stall is low, one sample is taken every cycle;
//   the one 16x16 multiply-add per sample sits between those two registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; sample_stall rises once both are occupied.
//   Registers sit at APB byte addresses 0, 4, 8 and 12; the user must write
//   them only while the stream is idle; the block does not enforce this.
//   Synchronous reset clears the registers, the delayed sample and both stages.
// ----------------------------------------------------------------------------
module pre_emphasis_sample_converter #(
  parameter int MAX_CHANNELS = pesc_pkg::MAX_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pesc_pkg::PADDR_W-1:0]          paddr,
  input  logic [pesc_pkg::PDATA_W-1:0]          pwdata,
  output logic [pesc_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [pesc_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic [pesc_pkg::CHANNEL_W-1:0]        channel_index,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [pesc_pkg::RESULT_W-1:0]  filtered_sample
);

  pesc_pkg::cfg_t cfg;

  logic                                 s1_valid;
  logic [pesc_pkg::SAMPLE_W-1:0]        s1_sample;
  logic [pesc_pkg::CHANNEL_W-1:0]       s1_channel;
  logic signed [pesc_pkg::RESULT_W-1:0] prev;
  logic signed [pesc_pkg::RESULT_W-1:0] prev_next;
  logic signed [pesc_pkg::RESULT_W-1:0] result;
  logic                                 out_free;
  logic                                 emit;
  logic                                 advance;

  pesc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pesc_datapath u_datapath (
    .cfg       (cfg),
    .sample    (s1_sample),
    .prev      (prev),
    .result    (result),
    .prev_next (prev_next)
  );

  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = s1_valid && !out_free;
  assign advance      = s1_valid && out_free;
  assign emit         = (s1_channel == cfg.selected_channel) &&
                        (32'(s1_channel) < MAX_CHANNELS);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_sample  <= sample_value;
      s1_channel <= channel_index;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      filtered_sample <= result;
    end
  end

  // delayed sample advances only on a filtered transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (advance && emit && cfg.emphasis_enable) begin
      prev <= prev_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_prev_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(prev))
    else $error("delayed sample changed while the output was stalled");

  a_prev_held_when_off: assert property (@(posedge clk) disable iff (rst)
    !cfg.emphasis_enable |=> $stable(prev))
    else $error("delayed sample changed with emphasis off");

  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && emit))
    else $error("result appeared without a matching sample");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pre-emphasis sample converter. Samples go in on
// the valid/stall stream with random sender gaps and receiver stalls. A
// scoreboard predicts each filtered sample from the register settings and
// the delayed sample, then compares it with what leaves the block. Registers
// are rewritten over APB between phases while the stream is drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 113;

  // Code three has no name in the package; the block treats it as 32-bit.
  localparam logic [pesc_pkg::FORMAT_W-1:0] FMT_S32_ALT = 2'd3;

  class emphasis_scoreboard;
    logic [pesc_pkg::FORMAT_W-1:0]      fmt;
    logic                               enable;
    logic signed [pesc_pkg::COEF_W-1:0] coef;
    logic [pesc_pkg::CHANNEL_W-1:0]     chan;
    logic signed [15:0]                 delayed;
    logic signed [15:0]                 expected_samples[$];
    int                                 errors;

    function new();
      fmt = pesc_pkg::FMT_S16;
      enable = 1'b0;
      coef = '0;
      chan = '0;
      delayed = '0;
      errors = 0;
    endfunction

    function void write_reg(pesc_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        pesc_pkg::REG_FORMAT:  fmt = value[pesc_pkg::FORMAT_W-1:0];
        pesc_pkg::REG_ENABLE:  enable = value[0];
        pesc_pkg::REG_COEF:    coef = value[pesc_pkg::COEF_W-1:0];
        pesc_pkg::REG_CHANNEL: chan = value[pesc_pkg::CHANNEL_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Add half an LSB of Q15, then drop the rest.
    function longint round_q15(longint v, int frac_bits);
      return ((v >>> (frac_bits - 16)) + 1) >>> 1;
    endfunction

    function void note_sample(logic [pesc_pkg::SAMPLE_W-1:0] value,
                              logic [pesc_pkg::CHANNEL_W-1:0] ch);
      longint s;
      longint acc;
      longint d;
      longint c;
      longint r;
      if (ch != chan) return;
      d = delayed;
      c = coef;
      if (fmt == pesc_pkg::FMT_S16) begin
        s = $signed(value[15:0]);
        if (enable) begin
          acc = d * c + s * 32768;
          r = clip16(round_q15(acc, 30));
          delayed = s[15:0];
        end else begin
          r = s;
        end
      end else begin
        if (fmt == pesc_pkg::FMT_S24) begin
          s = $signed(value[23:0]);
          s = s * 256;
        end else begin
          s = $signed(value);
        end
        if (enable) begin
          acc = d * c + (s >>> 1);
          r = clip16(round_q15(acc, 30));
          delayed = clip16(round_q15(s, 31));
        end else begin
          r = clip16(round_q15(s, 31));
        end
      end
      expected_samples.push_back(r[15:0]);
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d", got);
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                                  clk;
  logic                                  rst;
  logic                                  psel;
  logic                                  penable;
  logic                                  pwrite;
  logic [pesc_pkg::PADDR_W-1:0]          paddr;
  logic [pesc_pkg::PDATA_W-1:0]          pwdata;
  logic [pesc_pkg::PDATA_W-1:0]          prdata;
  logic                                  pready;
  logic                                  sample_valid;
  logic                                  sample_stall;
  logic signed [pesc_pkg::SAMPLE_W-1:0]  sample_value;
  logic [pesc_pkg::CHANNEL_W-1:0]        channel_index;
  logic                                  result_valid;
  logic                                  result_stall;
  logic signed [pesc_pkg::RESULT_W-1:0]  filtered_sample;

  emphasis_scoreboard sb;
  bit calm;
  int cycles;

  pre_emphasis_sample_converter dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_value(sample_value),
    .channel_index(channel_index),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .filtered_sample(filtered_sample)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_sample(filtered_sample);
  end

  // Receiver: random stall bursts, none once the run calms down.
  initial begin
    result_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // All tasks start and end at a falling edge.
  task automatic apb_write(pesc_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // the bus idles before the next setup phase
    @(negedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [1:0] fmt, logic en, logic [15:0] coef, logic [2:0] ch);
    drain();
    apb_write(pesc_pkg::REG_FORMAT, 32'(fmt));
    apb_write(pesc_pkg::REG_ENABLE, 32'(en));
    apb_write(pesc_pkg::REG_COEF, 32'(coef));
    apb_write(pesc_pkg::REG_CHANNEL, 32'(ch));
  endtask

  task automatic send_sample(logic [pesc_pkg::SAMPLE_W-1:0] value,
                             logic [pesc_pkg::CHANNEL_W-1:0] ch);
    sample_valid <= 1'b1;
    sample_value <= value;
    channel_index <= ch;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(value, ch);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    sample_valid <= 1'b0;
    repeat ($urandom_range(1, 13)) @(negedge clk);
  endtask

  function automatic logic [pesc_pkg::SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return r;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return {r[31:16], 16'h7FFF};
          1: return {r[31:16], 16'h8000};
          2: return {r[31:16], 16'h0000};
          default: return {r[31:16], 16'hFFFF};
        endcase
      end
      3: return {r[31:24], ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000) ^ 24'(r[3:0])};
      4: return 32'($signed($urandom_range(0, 1023)) - 512);
      default: return {r[31:17], 1'b0, r[15:0]} ^ {1'($urandom_range(0, 1)), 31'd0};
    endcase
  endfunction

  initial begin
    logic [2:0] ch;
    logic [15:0] coef;
    bit gaps;
    sb = new();
    calm = 1'b0;
    cycles = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_valid = 1'b0;
    sample_value = '0;
    channel_index = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: 16-bit, plain conversion, channel 0; high bits ignored.
    send_sample(32'h0000_7FFF, 3'd0);
    send_sample(32'hFFFF_8000, 3'd0);
    send_sample(32'hABCD_1234, 3'd0);
    send_sample(32'h1234_5678, 3'd3);

    // Most negative coefficient drives the sum into saturation both ways.
    configure(pesc_pkg::FMT_S16, 1'b1, 16'h8000, 3'd7);
    send_sample(32'h0000_7FFF, 3'd7);
    send_sample(32'h0000_8000, 3'd7);
    send_sample(32'h0000_8000, 3'd7);
    send_sample(32'h0000_7FFF, 3'd6);
    send_sample(32'h0000_0000, 3'd7);

    configure(pesc_pkg::FMT_S24, 1'b1, 16'h7FFF, 3'd2);
    send_sample(32'h007F_FFFF, 3'd2);
    send_sample(32'h0080_0000, 3'd2);
    send_sample(32'hFF7F_FFFF, 3'd2);
    send_sample(32'h0000_0080, 3'd2);

    configure(pesc_pkg::FMT_S32, 1'b0, 16'h0000, 3'd5);
    send_sample(32'h7FFF_FFFF, 3'd5);
    send_sample(32'h8000_0000, 3'd5);
    send_sample(32'h0000_8000, 3'd5);
    send_sample(32'hFFFF_7FFF, 3'd5);

    configure(FMT_S32_ALT, 1'b1, 16'd12345, 3'd1);
    send_sample(32'h7FFF_FFFF, 3'd1);
    send_sample(32'h8000_0000, 3'd1);
    send_sample(32'h1234_5678, 3'd1);
    send_sample(32'h1234_5678, 3'd4);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: coef = 16'h7FFF;
        1: coef = 16'h8000;
        2: coef = 16'h0000;
        default: coef = 16'($urandom);
      endcase
      if (p >= PHASES - 2) calm = 1'b1;
      gaps = !calm && (p % 3 != 2);
      configure(2'(p % 4), (p % 3 != 0), coef, 3'(p % 8 == 1 ? 7 : $urandom_range(0, 7)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        ch = ($urandom_range(0, 9) < 7) ? sb.chan : 3'($urandom_range(0, 7));
        send_sample(pick_sample(), ch);
        if (p == 3 && i == PHASE_ITEMS / 2) drain();
        else if (gaps && $urandom_range(0, 5) == 0) sender_gap();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pesc_pkg.sv
rtl/core/pesc_regs.sv
rtl/core/pesc_datapath.sv
rtl/core/pre_emphasis_sample_converter.sv
test/tb_top.sv
